// ===== sv/iplpm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iplpm_pkg
// Shared sizes, status codes and route entry layout of the IPv4 router.
// ----------------------------------------------------------------------------
package iplpm_pkg;

    // Route table depth and derived index / count widths
    localparam int MAX_ROUTES = 16;
    localparam int IDX_W      = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int CNT_W      = $clog2(MAX_ROUTES + 1);

    // Field widths
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int IFC_W  = 3;
    localparam int TTL_W  = 8;
    localparam int STS_W  = 3;

    // Operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_ROUTE = 1'b1;

    // Result status codes
    localparam logic [STS_W-1:0] ST_ADDED       = 3'd0;
    localparam logic [STS_W-1:0] ST_FULL        = 3'd1;
    localparam logic [STS_W-1:0] ST_FORWARDED   = 3'd2;
    localparam logic [STS_W-1:0] ST_NO_ROUTE    = 3'd3;
    localparam logic [STS_W-1:0] ST_TTL_EXPIRED = 3'd4;

    localparam logic [LEN_W-1:0] FULL_LEN = 6'd32;

    // One route table entry
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic              has_gw;
        logic [ADDR_W-1:0] gw;
        logic [IFC_W-1:0]  ifc;
    } route_t;

    // Network mask for a prefix length of 0 to 32
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] sh;
        sh = FULL_LEN - len;
        return (len == '0) ? '0 : ({ADDR_W{1'b1}} << sh);
    endfunction

endpackage
`default_nettype wire

// ===== sv/ipv4_longest_prefix_router.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_router
// IPv4 route table with longest-prefix lookup and TTL handling.
// ----------------------------------------------------------------------------
// Routes live in one synchronous RAM of MAX_ROUTES entries and are appended
// in arrival order; an add to a full table returns ST_FULL. A route word
// walks the table one entry per cycle through the RAM read port, keeping the
// longest match (the later entry wins a tie), then returns forwarded, no
// route or ttl expired. Every word, add or lookup, gives one result word.
// A lookup scans every stored entry through the single RAM read port. Input
// is accepted only between words; a finished result may still wait on m_ready
// while the next word is taken.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_router
    import iplpm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_op,
    input  wire logic [ADDR_W-1:0] s_route_prefix,
    input  wire logic [LEN_W-1:0]  s_prefix_length,
    input  wire logic              s_has_next_hop,
    input  wire logic [ADDR_W-1:0] s_gateway_addr,
    input  wire logic [IFC_W-1:0]  s_interface_index,
    input  wire logic [ADDR_W-1:0] s_dest_addr,
    input  wire logic [TTL_W-1:0]  s_ttl_in,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [STS_W-1:0]       m_status,
    output logic [IFC_W-1:0]       m_out_interface,
    output logic [ADDR_W-1:0]      m_next_hop_out,
    output logic [TTL_W-1:0]       m_ttl_out
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  iss_reg;
    logic              iss_on_reg;
    logic              rd_vld_reg;
    logic              rd_last_reg;
    route_t            rd_data_reg;
    route_t            mem [MAX_ROUTES];

    logic [ADDR_W-1:0] dst_reg;
    logic [TTL_W-1:0]  ttl_reg;
    logic              found_reg;
    route_t            best_reg;

    logic [STS_W-1:0]  pend_sts_reg;
    logic [IFC_W-1:0]  pend_ifc_reg;
    logic [ADDR_W-1:0] pend_nh_reg;
    logic [TTL_W-1:0]  pend_ttl_reg;

    logic              m_valid_reg;
    logic [STS_W-1:0]  m_sts_reg;
    logic [IFC_W-1:0]  m_ifc_reg;
    logic [ADDR_W-1:0] m_nh_reg;
    logic [TTL_W-1:0]  m_ttl_reg;

    logic              accept;
    logic              full;
    logic              wr_en;
    route_t            wr_entry;
    logic [LEN_W-1:0]  sat_len;
    logic              iss_last;
    logic              hit;
    logic              found_next;
    route_t            best_next;
    logic              out_free;

    assign s_ready  = aresetn && (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign full     = (cnt_reg == CNT_W'(MAX_ROUTES));
    assign out_free = !m_valid_reg || m_ready;
    assign iss_last = (CNT_W'(iss_reg) == cnt_reg - CNT_W'(1));

    // Build the entry of an added route, length saturated to 32
    always_comb begin
        sat_len         = (s_prefix_length > FULL_LEN) ? FULL_LEN : s_prefix_length;
        wr_entry.prefix = s_route_prefix;
        wr_entry.len    = sat_len;
        wr_entry.has_gw = s_has_next_hop;
        wr_entry.gw     = s_gateway_addr;
        wr_entry.ifc    = s_interface_index;
        wr_en           = accept && (s_op == OP_ADD) && !full;
    end

    // Route table RAM: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cnt_reg[IDX_W-1:0]] <= wr_entry;
        end
        rd_data_reg <= mem[iss_reg];
    end

    // Compare the entry read last cycle against the destination
    always_comb begin
        hit = rd_vld_reg
            && (((dst_reg ^ rd_data_reg.prefix) & prefix_mask(rd_data_reg.len)) == '0)
            && (!found_reg || (rd_data_reg.len >= best_reg.len));
        found_next = found_reg || hit;
        best_next  = hit ? rd_data_reg : best_reg;
    end

    // Sequencer, scan counter and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            iss_reg     <= '0;
            iss_on_reg  <= 1'b0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_vld_reg  <= iss_on_reg;
            rd_last_reg <= iss_on_reg && iss_last;
            // Drop the output word once taken, unless a new one replaces it
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        dst_reg      <= s_dest_addr;
                        ttl_reg      <= s_ttl_in;
                        found_reg    <= 1'b0;
                        pend_ifc_reg <= '0;
                        pend_nh_reg  <= '0;
                        pend_ttl_reg <= '0;
                        if (s_op == OP_ADD) begin
                            pend_sts_reg <= full ? ST_FULL : ST_ADDED;
                            if (!full) begin
                                cnt_reg <= cnt_reg + CNT_W'(1);
                            end
                            state_reg <= S_DONE;
                        end else if (cnt_reg == '0) begin
                            pend_sts_reg <= ST_NO_ROUTE;
                            state_reg    <= S_DONE;
                        end else begin
                            iss_reg    <= '0;
                            iss_on_reg <= 1'b1;
                            state_reg  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Advance the read address until the last valid entry
                    if (iss_on_reg) begin
                        if (iss_last) begin
                            iss_on_reg <= 1'b0;
                        end else begin
                            iss_reg <= iss_reg + IDX_W'(1);
                        end
                    end
                    if (rd_vld_reg) begin
                        found_reg <= found_next;
                        best_reg  <= best_next;
                    end
                    // Form the lookup result after the last compare
                    if (rd_last_reg) begin
                        if (!found_next) begin
                            pend_sts_reg <= ST_NO_ROUTE;
                        end else if (ttl_reg <= TTL_W'(1)) begin
                            pend_sts_reg <= ST_TTL_EXPIRED;
                        end else begin
                            pend_sts_reg <= ST_FORWARDED;
                            pend_ifc_reg <= best_next.ifc;
                            pend_nh_reg  <= best_next.has_gw ? best_next.gw : dst_reg;
                            pend_ttl_reg <= ttl_reg - TTL_W'(1);
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hand the result to the output register once it is free
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_sts_reg   <= pend_sts_reg;
                        m_ifc_reg   <= pend_ifc_reg;
                        m_nh_reg    <= pend_nh_reg;
                        m_ttl_reg   <= pend_ttl_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_sts_reg;
    assign m_out_interface = m_ifc_reg;
    assign m_next_hop_out  = m_nh_reg;
    assign m_ttl_out       = m_ttl_reg;

endmodule
`default_nettype wire
